### rtl/core/dsdu_pkg.sv
// dsdu_pkg: shared codes and constants of the display shadow diff updater
// no dependencies; imported by display_shadow_diff_updater
`default_nettype none

package dsdu_pkg;

  // input op codes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CURSOR = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  // change counter
  localparam int          CNT_W     = 7;
  localparam logic [6:0]  COUNT_MAX = 7'd127;

endpackage

`default_nettype wire

### rtl/core/display_shadow_diff_updater.sv
// display_shadow_diff_updater: character display refresh engine, top level
// holds the shadow character memory, valid bits and the result sequencer
// depends on dsdu_pkg
//
// Usage
//   Input channel (in_valid / in_stall): one beat per frame cell in raster
//   order, or a clear beat (in_op = 1) that drops every shadow entry to zero.
//   Result channel (out_valid / out_stall): per cell a write-char beat if
//   the character differs from the shadow, led by a set-cursor beat when
//   the cell starts a row or follows a skipped cell, then a frame-done beat
//   on the last cell of a frame; out_last marks each input beat's final beat.
//   The shadow is read on the accepting edge into the compare stage; the
//   compare result is registered into the output register. Throughput: one
//   input beat per cycle while each beat causes at most one result and the
//   output is not stalled; a beat with more results holds the input side
//   until all its result beats are taken, one result beat per cycle.
//   The shadow memory has one write port and one read port; a read of the
//   entry being written back in the same cycle is forwarded.
//   Reset clears all valid bits at once, so the shadow reads as zero straight
//   away; no clearing pass. While a full output register is stalled, an item
//   with result beats pending stays in the compare stage, holding in_stall high.
`default_nettype none

module display_shadow_diff_updater
  import dsdu_pkg::*;
#(
  parameter int NUM_COLS = 20,
  parameter int NUM_ROWS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_op,
  input  wire logic [4:0] in_cell_col,
  input  wire logic [1:0] in_cell_row,
  input  wire logic [7:0] in_cell_char,
  input  wire logic       in_frame_end,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [4:0]      out_cursor_col,
  output logic [1:0]      out_cursor_row,
  output logic [7:0]      out_char,
  output logic [6:0]      out_changed_count,
  output logic            out_last
);

  localparam int CELLS = NUM_COLS * NUM_ROWS;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // shadow store and valid bits
  logic [7:0]       mem [CELLS];
  logic [CELLS-1:0] vld_r;
  logic [7:0]       rd_r;

  // compare stage
  logic             s1_valid_r;
  logic             s1_op_r;
  logic [4:0]       s1_col_r;
  logic [1:0]       s1_row_r;
  logic [7:0]       s1_char_r;
  logic             s1_fend_r;
  logic             s1_grid_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             fwd_r;
  logic [7:0]       fwd_d_r;
  logic [2:0]       done_r;

  // frame state
  logic             cur_need_r;
  logic [CNT_W-1:0] frame_cnt_r;

  // output register
  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [4:0]       out_col_r;
  logic [1:0]       out_row_r;
  logic [7:0]       out_char_r;
  logic [6:0]       out_cnt_r;
  logic             out_last_r;

  logic             in_acc;
  logic             in_grid;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       held;
  logic             diff;
  logic             is_clear;
  logic [2:0]       pres;
  logic [2:0]       pend;
  logic [2:0]       cur;
  logic             is_last;
  logic             out_free;
  logic             emit;
  logic             fin;
  logic             wr_en;
  logic [CNT_W-1:0] cnt_new;
  logic             cur_need_nxt;
  logic [CNT_W-1:0] frame_cnt_nxt;
  logic [1:0]       res_kind;
  logic [4:0]       res_col;
  logic [1:0]       res_row;
  logic [7:0]       res_char;
  logic [6:0]       res_cnt;

  // input decode and read address
  always_comb begin
    in_acc  = in_valid && !in_stall;
    in_grid = (32'(in_cell_col) < 32'(NUM_COLS)) && (32'(in_cell_row) < 32'(NUM_ROWS));
    if (in_grid) begin
      rd_idx = IDX_W'(32'(in_cell_row) * 32'(NUM_COLS) + 32'(in_cell_col));
    end else begin
      rd_idx = '0;
    end
  end

  // compare and result presence
  always_comb begin
    is_clear = (s1_op_r == OP_CLEAR);
    if (!vld_r[s1_idx_r]) begin
      held = 8'd0;
    end else if (fwd_r) begin
      held = fwd_d_r;
    end else begin
      held = rd_r;
    end
    diff    = s1_grid_r && !is_clear && (held != s1_char_r);
    pres[0] = diff && (cur_need_r || (s1_col_r == 5'd0));
    pres[1] = diff;
    pres[2] = !is_clear && s1_fend_r;
    pend    = pres & ~done_r;
  end

  // pick the next result beat in order: cursor, write, frame done
  always_comb begin
    priority if (pend[0]) begin
      cur = 3'b001;
    end else if (pend[1]) begin
      cur = 3'b010;
    end else if (pend[2]) begin
      cur = 3'b100;
    end else begin
      cur = 3'b000;
    end
    is_last  = ((pend & ~cur) == 3'b000);
    out_free = !out_valid_r || !out_stall;
    emit     = s1_valid_r && (pend != 3'b000) && out_free;
    fin      = s1_valid_r && ((pend == 3'b000) || (emit && is_last));
    in_stall = s1_valid_r && !fin;
    wr_en    = fin && diff;
  end

  // change count and cursor state after this cell
  always_comb begin
    cnt_new = frame_cnt_r;
    if (diff && (frame_cnt_r != COUNT_MAX)) begin
      cnt_new = frame_cnt_r + CNT_W'(1);
    end
    cur_need_nxt  = cur_need_r;
    frame_cnt_nxt = frame_cnt_r;
    if (!is_clear) begin
      if (!s1_grid_r) begin
        cur_need_nxt = 1'b1;
      end else begin
        cur_need_nxt = !diff;
      end
      frame_cnt_nxt = cnt_new;
      if (s1_fend_r) begin
        cur_need_nxt  = 1'b1;
        frame_cnt_nxt = '0;
      end
    end
  end

  // result beat fields
  always_comb begin
    res_kind = KIND_DONE;
    res_col  = 5'd0;
    res_row  = 2'd0;
    res_char = 8'd0;
    res_cnt  = 7'd0;
    unique case (1'b1)
      cur[0]: begin
        res_kind = KIND_CURSOR;
        res_col  = s1_col_r;
        res_row  = s1_row_r;
      end
      cur[1]: begin
        res_kind = KIND_WRITE;
        res_char = s1_char_r;
      end
      default: begin
        res_kind = KIND_DONE;
        res_cnt  = cnt_new;
      end
    endcase
  end

  // shadow memory: write back on completion, registered read on accept
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx_r] <= s1_char_r;
    end
    if (in_acc) begin
      rd_r <= mem[rd_idx];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (fin && is_clear) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_idx_r] <= 1'b1;
    end
  end

  // compare stage payload and forwarding of a same-cycle write back
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_col_r  <= in_cell_col;
      s1_row_r  <= in_cell_row;
      s1_char_r <= in_cell_char;
      s1_fend_r <= in_frame_end;
      s1_grid_r <= in_grid;
      s1_idx_r  <= rd_idx;
      fwd_d_r   <= s1_char_r;
    end
  end

  // compare stage control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      done_r      <= 3'b000;
      cur_need_r  <= 1'b1;
      frame_cnt_r <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= wr_en && in_grid && (s1_idx_r == rd_idx);
      end else if (fin) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
      if (fin) begin
        done_r      <= 3'b000;
        cur_need_r  <= cur_need_nxt;
        frame_cnt_r <= frame_cnt_nxt;
      end else if (emit) begin
        done_r <= done_r | cur;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= res_kind;
      out_col_r  <= res_col;
      out_row_r  <= res_row;
      out_char_r <= res_char;
      out_cnt_r  <= res_cnt;
      out_last_r <= is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_char          = out_char_r;
  assign out_changed_count = out_cnt_r;
  assign out_last          = out_last_r;

  // checks
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input held with empty compare stage");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_DONE)) |-> out_last)
    else $error("frame done beat not last");

  a_cursor_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_CURSOR)) |-> !out_last)
    else $error("set cursor beat without following write");

  a_fwd_stage: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forward flag without item in compare stage");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !is_last && !fin) |=> s1_valid_r)
    else $error("item left compare stage with beats pending");

endmodule

`default_nettype wire
